/* rtl/sdsb_pkg.sv */
`timescale 1ns / 1ps
package sdsb_pkg;

  localparam int unsigned RING_DEPTH     = 4096;
  localparam int unsigned SCREEN_COLUMNS = 320;
  localparam int unsigned SCREEN_ROWS    = 240;
  localparam int unsigned SAMPLE_RATE    = 50000;
  localparam int unsigned ADC_MID        = 2048;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned ROW_W    = 8;
  localparam int unsigned CURSOR_W = 8;
  localparam int unsigned CODE_W   = 12;
  localparam int unsigned TB_W     = 3;
  localparam int unsigned RING_AW  = $clog2(RING_DEPTH);
  localparam int unsigned COL_W    = $clog2(SCREEN_COLUMNS + 1);
  localparam int unsigned COL_AW   = $clog2(SCREEN_COLUMNS);

  localparam int unsigned ROW_CENTER = SCREEN_ROWS / 2;
  localparam int unsigned ROW_MAX    = SCREEN_ROWS - 1;
  localparam int unsigned ROW_SCALE  = 3842;
  localparam int unsigned ROW_SHIFT  = 16;
  localparam int unsigned CODE_SCALE = 1092;
  localparam int unsigned CODE_SHIFT = 6;
  localparam int unsigned CODE_MAX   = 4095;

  localparam logic [TB_W-1:0] TIMEBASE_RESET = 3'd2;

  // config port
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 32;
  localparam logic [0:0]  REG_TIMEBASE = 1'b0;

  typedef int unsigned ms_tab_t [8];
  localparam ms_tab_t WINDOW_MS = '{8, 16, 32, 64, 160, 320, 640, 32};

  function automatic longint unsigned spw_of(int unsigned i);
    return longint'(SAMPLE_RATE) * longint'(WINDOW_MS[i]) / 1000;
  endfunction

  function automatic longint unsigned dec_of(int unsigned i);
    longint unsigned d;
    d = spw_of(i) / SCREEN_COLUMNS;
    return (d < 1) ? 1 : d;
  endfunction

  function automatic longint unsigned off_of(int unsigned i);
    longint unsigned s;
    s = spw_of(i);
    return (s >= RING_DEPTH) ? longint'(RING_DEPTH - 1) : s;
  endfunction

  function automatic longint unsigned dec_max();
    longint unsigned m;
    m = 1;
    for (int unsigned i = 0; i < 8; i++) begin
      if (dec_of(i) > m) m = dec_of(i);
    end
    return m;
  endfunction

  localparam int unsigned DEC_W = $clog2(dec_max() + 1);

  typedef logic [DEC_W-1:0]   dec_tab_t [8];
  typedef logic [RING_AW-1:0] off_tab_t [8];

  localparam dec_tab_t DEC_TAB = '{
    DEC_W'(dec_of(0)), DEC_W'(dec_of(1)), DEC_W'(dec_of(2)), DEC_W'(dec_of(3)),
    DEC_W'(dec_of(4)), DEC_W'(dec_of(5)), DEC_W'(dec_of(6)), DEC_W'(dec_of(7))
  };

  localparam off_tab_t OFF_TAB = '{
    RING_AW'(off_of(0)), RING_AW'(off_of(1)), RING_AW'(off_of(2)), RING_AW'(off_of(3)),
    RING_AW'(off_of(4)), RING_AW'(off_of(5)), RING_AW'(off_of(6)), RING_AW'(off_of(7))
  };

  // shared multiplier widths
  localparam int unsigned MUL_A_W = (COL_W > SAMPLE_W) ? COL_W : SAMPLE_W;
  localparam int unsigned MUL_B_W = (DEC_W > 12) ? DEC_W : 12;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_TICK    = 2'd1,
    KIND_CURSOR  = 2'd2,
    KIND_RESTART = 2'd3
  } kind_t;

  localparam logic RES_TICK   = 1'b0;
  localparam logic RES_CURSOR = 1'b1;

  typedef enum logic [1:0] {
    MUL_IDX,
    MUL_ROW,
    MUL_CODE
  } mul_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_T_IDX,
    S_T_RD,
    S_T_MAG,
    S_T_MUL,
    S_T_OUT,
    S_C_WALK,
    S_C_MUL,
    S_C_OUT
  } state_t;

endpackage

/* rtl/sdsb_ram.sv */
`timescale 1ns / 1ps
module sdsb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/sdsb_mul.sv */
`timescale 1ns / 1ps
module sdsb_mul import sdsb_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  mul_op_t             op,
  input  logic [COL_W-1:0]    col,
  input  logic [DEC_W-1:0]    dec,
  input  logic [SAMPLE_W-1:0] sample_mag,
  input  logic [ROW_W-1:0]    row_mag,
  output logic [MUL_P_W-1:0]  p
);

  logic [MUL_A_W-1:0] a;
  logic [MUL_B_W-1:0] b;
  logic [MUL_P_W-1:0] p_r;

  always_comb begin
    case (op)
      MUL_IDX: begin
        a = MUL_A_W'(col);
        b = MUL_B_W'(dec);
      end
      MUL_ROW: begin
        a = MUL_A_W'(sample_mag);
        b = MUL_B_W'(ROW_SCALE);
      end
      MUL_CODE: begin
        a = MUL_A_W'(row_mag);
        b = MUL_B_W'(CODE_SCALE);
      end
      default: begin
        a = '0;
        b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= MUL_P_W'(a) * MUL_P_W'(b);
    end
  end

  assign p = p_r;

endmodule

/* rtl/scope_decimating_sweep_buffer.sv */
`timescale 1ns / 1ps
// channel   | handshake              | beat
// ----------+------------------------+--------------------------------------------
// in        | in_valid / in_ready    | in_kind, in_sample, in_cursor_row
// out       | out_valid / out_ready  | out_result_kind .. out_cursor_found
// cfg       | apb psel/penable/pready| timebase at paddr 0
//
// sample and restart beats are taken in idle and can follow back to back
// a tick steps through index multiply, ring read, offset, row multiply, store
// a cursor query walks the stored rows of the sweep, then scales the nearest row to a code
// rst_n is synchronous; no clearing pass, fill marks stand in for memory reset
// a result waiting on out_ready holds the final step; samples still flow once idle
module scope_decimating_sweep_buffer import sdsb_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_kind,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic [CURSOR_W-1:0] in_cursor_row,

  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_result_kind,
  output logic [COL_W-1:0]    out_column,
  output logic [ROW_W-1:0]    out_row,
  output logic [ROW_W-1:0]    out_prev_row,
  output logic                out_draw_segment,
  output logic                out_sweep_restart,
  output logic [CODE_W-1:0]   out_cursor_code,
  output logic                out_cursor_found,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [CFG_DW-1:0]   pwdata,
  output logic [CFG_DW-1:0]   prdata,
  output logic                pready
);

  localparam int unsigned M_W  = MUL_P_W - ROW_SHIFT;
  localparam int unsigned Q_W  = MUL_P_W - CODE_SHIFT + 1;
  localparam int unsigned RW_W = ROW_W + 2;

  state_t state_r, state_nxt;

  logic [TB_W-1:0]     timebase_r;
  logic [RING_AW-1:0]  wp_r, wp_nxt;
  logic                ring_full_r, ring_full_nxt;
  logic [COL_W-1:0]    col_cnt_r, col_cnt_nxt;
  logic [COL_W-1:0]    rows_hwm_r, rows_hwm_nxt;
  logic [COL_W-1:0]    sweep_hwm_r, sweep_hwm_nxt;
  logic                swept_r, swept_nxt;

  logic [COL_W-1:0]    col_r, col_nxt;
  logic                wrapped_r, wrapped_nxt;
  logic [RING_AW-1:0]  idx_r, idx_nxt;
  logic [SAMPLE_W-1:0] mag_r, mag_nxt;
  logic                neg_r, neg_nxt;
  logic [ROW_W-1:0]    row_mag_r, row_mag_nxt;

  logic [CURSOR_W-1:0] cur_r, cur_nxt;
  logic [COL_W-1:0]    limit_r, limit_nxt;
  logic [COL_W-1:0]    j_r, j_nxt;
  logic                pv_r, pv_nxt;
  logic [COL_W-1:0]    pj_r, pj_nxt;
  logic [ROW_W-1:0]    best_r, best_nxt;
  logic [ROW_W-1:0]    best_row_r, best_row_nxt;
  logic                found_r, found_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                o_kind_r, o_kind_nxt;
  logic [COL_W-1:0]    o_col_r, o_col_nxt;
  logic [ROW_W-1:0]    o_row_r, o_row_nxt;
  logic [ROW_W-1:0]    o_prev_r, o_prev_nxt;
  logic                o_seg_r, o_seg_nxt;
  logic                o_wrap_r, o_wrap_nxt;
  logic [CODE_W-1:0]   o_code_r, o_code_nxt;
  logic                o_found_r, o_found_nxt;

  logic                ring_we, ring_re;
  logic [RING_AW-1:0]  ring_raddr;
  logic [SAMPLE_W-1:0] ring_q;
  logic                rows_we, rows_re;
  logic [COL_AW-1:0]   rows_waddr, rows_raddr;
  logic [ROW_W-1:0]    rows_wdata, rows_q;

  logic                mul_en;
  mul_op_t             mul_op;
  logic [MUL_P_W-1:0]  mul_p;

  logic                accept, out_free, cfg_wr;
  logic [RING_AW-1:0]  start;
  logic [SAMPLE_W-1:0] smp;
  logic [M_W-1:0]      m;
  logic [RW_W-1:0]     row_wide;
  logic [ROW_W-1:0]    row_val;
  logic                issue;
  logic [ROW_W-1:0]    walk_row, row_gap;
  logic                walk_ok;
  logic [Q_W-1:0]      q_pos, q_neg;
  logic [Q_W:0]        code_wide;
  logic [COL_W-1:0]    col_inc;

  sdsb_ram #(.WIDTH(SAMPLE_W), .DEPTH(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (wp_r),
    .wdata (in_sample),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_q)
  );

  sdsb_ram #(.WIDTH(ROW_W), .DEPTH(SCREEN_COLUMNS)) u_rows (
    .clk   (clk),
    .we    (rows_we),
    .waddr (rows_waddr),
    .wdata (rows_wdata),
    .re    (rows_re),
    .raddr (rows_raddr),
    .rdata (rows_q)
  );

  sdsb_mul u_mul (
    .clk        (clk),
    .en         (mul_en),
    .op         (mul_op),
    .col        (col_r),
    .dec        (DEC_TAB[timebase_r]),
    .sample_mag (mag_r),
    .row_mag    (row_mag_r),
    .p          (mul_p)
  );

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[CFG_AW-1 -: 1] == REG_TIMEBASE);
  assign prdata = (paddr[CFG_AW-1 -: 1] == REG_TIMEBASE) ? CFG_DW'(timebase_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timebase_r <= TIMEBASE_RESET;
    end else if (cfg_wr) begin
      timebase_r <= pwdata[TB_W-1:0];
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  assign start = RING_AW'(wp_r - OFF_TAB[timebase_r]);
  assign smp   = (ring_full_r || idx_r < wp_r) ? ring_q : '0;
  assign m     = mul_p[MUL_P_W-1:ROW_SHIFT];

  always_comb begin
    if (neg_r) begin
      row_wide = (RW_W'(m) > RW_W'(ROW_CENTER)) ? '0 : RW_W'(ROW_CENTER) - RW_W'(m);
    end else begin
      row_wide = RW_W'(ROW_CENTER) + RW_W'(m);
      if (row_wide > RW_W'(ROW_MAX)) row_wide = RW_W'(ROW_MAX);
    end
  end
  assign row_val = row_wide[ROW_W-1:0];
  assign col_inc = COL_W'(col_r + 1'b1);

  assign issue    = j_r < limit_r;
  assign walk_row = (pj_r < rows_hwm_r) ? rows_q : '0;
  assign walk_ok  = !swept_r || (pj_r < sweep_hwm_r);
  assign row_gap  = (walk_row > cur_r) ? walk_row - cur_r : cur_r - walk_row;

  // floor (positive side) and ceiling (negative side) of the scaled offset over 64
  assign q_pos = Q_W'(mul_p >> CODE_SHIFT);
  assign q_neg = Q_W'((MUL_P_W'(mul_p) + MUL_P_W'((1 << CODE_SHIFT) - 1)) >> CODE_SHIFT);

  always_comb begin
    if (neg_r) begin
      code_wide = (q_neg > Q_W'(ADC_MID)) ? '0 : (Q_W + 1)'(ADC_MID) - (Q_W + 1)'(q_neg);
    end else begin
      code_wide = (Q_W + 1)'(ADC_MID) + (Q_W + 1)'(q_pos);
      if (code_wide > (Q_W + 1)'(CODE_MAX)) code_wide = (Q_W + 1)'(CODE_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      ring_full_r <= 1'b0;
      col_cnt_r   <= '0;
      rows_hwm_r  <= '0;
      sweep_hwm_r <= '0;
      swept_r     <= 1'b0;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      ring_full_r <= ring_full_nxt;
      col_cnt_r   <= col_cnt_nxt;
      rows_hwm_r  <= rows_hwm_nxt;
      sweep_hwm_r <= sweep_hwm_nxt;
      swept_r     <= swept_nxt;
      out_valid_r <= out_valid_nxt;
      pv_r        <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r      <= col_nxt;
    wrapped_r  <= wrapped_nxt;
    idx_r      <= idx_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    row_mag_r  <= row_mag_nxt;
    cur_r      <= cur_nxt;
    limit_r    <= limit_nxt;
    j_r        <= j_nxt;
    pj_r       <= pj_nxt;
    best_r     <= best_nxt;
    best_row_r <= best_row_nxt;
    found_r    <= found_nxt;
    o_kind_r   <= o_kind_nxt;
    o_col_r    <= o_col_nxt;
    o_row_r    <= o_row_nxt;
    o_prev_r   <= o_prev_nxt;
    o_seg_r    <= o_seg_nxt;
    o_wrap_r   <= o_wrap_nxt;
    o_code_r   <= o_code_nxt;
    o_found_r  <= o_found_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    ring_full_nxt = ring_full_r;
    col_cnt_nxt   = col_cnt_r;
    rows_hwm_nxt  = rows_hwm_r;
    sweep_hwm_nxt = sweep_hwm_r;
    swept_nxt     = swept_r;
    col_nxt       = col_r;
    wrapped_nxt   = wrapped_r;
    idx_nxt       = idx_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    row_mag_nxt   = row_mag_r;
    cur_nxt       = cur_r;
    limit_nxt     = limit_r;
    j_nxt         = j_r;
    pv_nxt        = pv_r;
    pj_nxt        = pj_r;
    best_nxt      = best_r;
    best_row_nxt  = best_row_r;
    found_nxt     = found_r;

    out_valid_nxt = out_valid_r && !out_ready;
    o_kind_nxt    = o_kind_r;
    o_col_nxt     = o_col_r;
    o_row_nxt     = o_row_r;
    o_prev_nxt    = o_prev_r;
    o_seg_nxt     = o_seg_r;
    o_wrap_nxt    = o_wrap_r;
    o_code_nxt    = o_code_r;
    o_found_nxt   = o_found_r;

    ring_we    = 1'b0;
    ring_re    = 1'b0;
    ring_raddr = idx_r;
    rows_we    = 1'b0;
    rows_re    = 1'b0;
    rows_waddr = col_r[COL_AW-1:0];
    rows_wdata = row_val;
    rows_raddr = j_r[COL_AW-1:0];
    mul_en     = 1'b0;
    mul_op     = MUL_IDX;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (kind_t'(in_kind))
            KIND_SAMPLE: begin
              ring_we = 1'b1;
              wp_nxt  = RING_AW'(wp_r + 1'b1);
              if (wp_r == RING_AW'(RING_DEPTH - 1)) ring_full_nxt = 1'b1;
            end
            KIND_TICK: begin
              if (col_cnt_r >= COL_W'(SCREEN_COLUMNS)) begin
                col_nxt       = '0;
                wrapped_nxt   = 1'b1;
                swept_nxt     = 1'b1;
                sweep_hwm_nxt = '0;
              end else begin
                col_nxt     = col_cnt_r;
                wrapped_nxt = 1'b0;
              end
              state_nxt = S_T_IDX;
            end
            KIND_CURSOR: begin
              cur_nxt      = in_cursor_row;
              limit_nxt    = col_cnt_r;
              j_nxt        = '0;
              pv_nxt       = 1'b0;
              best_nxt     = ROW_W'(SCREEN_ROWS);
              best_row_nxt = '0;
              found_nxt    = 1'b0;
              state_nxt    = S_C_WALK;
            end
            KIND_RESTART: begin
              col_cnt_nxt = '0;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_T_IDX: begin
        mul_en    = 1'b1;
        mul_op    = MUL_IDX;
        state_nxt = S_T_RD;
      end

      S_T_RD: begin
        idx_nxt    = RING_AW'(start + mul_p[RING_AW-1:0]);
        ring_re    = 1'b1;
        ring_raddr = idx_nxt;
        rows_re    = 1'b1;
        rows_raddr = COL_AW'(col_r - 1'b1);
        state_nxt  = S_T_MAG;
      end

      S_T_MAG: begin
        if (smp >= SAMPLE_W'(ADC_MID)) begin
          mag_nxt = SAMPLE_W'(smp - SAMPLE_W'(ADC_MID));
          neg_nxt = 1'b0;
        end else begin
          mag_nxt = SAMPLE_W'((SAMPLE_W + 1)'(ADC_MID) - (SAMPLE_W + 1)'(smp));
          neg_nxt = 1'b1;
        end
        state_nxt = S_T_MUL;
      end

      S_T_MUL: begin
        mul_en    = 1'b1;
        mul_op    = MUL_ROW;
        state_nxt = S_T_OUT;
      end

      S_T_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_kind_nxt    = RES_TICK;
          o_col_nxt     = col_r;
          o_row_nxt     = row_val;
          o_wrap_nxt    = wrapped_r;
          o_code_nxt    = '0;
          o_found_nxt   = 1'b0;
          // previous column drawn in this sweep
          if (col_r != '0 && (!swept_r || col_r <= sweep_hwm_r)) begin
            o_seg_nxt  = 1'b1;
            o_prev_nxt = (col_r <= rows_hwm_r) ? rows_q : '0;
          end else begin
            o_seg_nxt  = 1'b0;
            o_prev_nxt = '0;
          end
          rows_we     = 1'b1;
          col_cnt_nxt = col_inc;
          if (col_inc > sweep_hwm_r) sweep_hwm_nxt = col_inc;
          if (col_inc > rows_hwm_r) rows_hwm_nxt = col_inc;
          state_nxt = S_IDLE;
        end
      end

      S_C_WALK: begin
        rows_re    = issue;
        rows_raddr = j_r[COL_AW-1:0];
        pv_nxt     = issue;
        pj_nxt     = j_r;
        if (issue) j_nxt = COL_W'(j_r + 1'b1);
        if (pv_r && walk_ok && row_gap < best_r) begin
          best_nxt     = row_gap;
          best_row_nxt = walk_row;
          found_nxt    = 1'b1;
        end
        if (!issue && !pv_r) begin
          if (best_row_r >= ROW_W'(ROW_CENTER)) begin
            row_mag_nxt = ROW_W'(best_row_r - ROW_W'(ROW_CENTER));
            neg_nxt     = 1'b0;
          end else begin
            row_mag_nxt = ROW_W'(ROW_W'(ROW_CENTER) - best_row_r);
            neg_nxt     = 1'b1;
          end
          state_nxt = S_C_MUL;
        end
      end

      S_C_MUL: begin
        mul_en    = 1'b1;
        mul_op    = MUL_CODE;
        state_nxt = S_C_OUT;
      end

      S_C_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_kind_nxt    = RES_CURSOR;
          o_col_nxt     = '0;
          o_row_nxt     = '0;
          o_prev_nxt    = '0;
          o_seg_nxt     = 1'b0;
          o_wrap_nxt    = 1'b0;
          o_code_nxt    = found_r ? code_wide[CODE_W-1:0] : '0;
          o_found_nxt   = found_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_result_kind   = o_kind_r;
  assign out_column        = o_col_r;
  assign out_row           = o_row_r;
  assign out_prev_row      = o_prev_r;
  assign out_draw_segment  = o_seg_r;
  assign out_sweep_restart = o_wrap_r;
  assign out_cursor_code   = o_code_r;
  assign out_cursor_found  = o_found_r;

endmodule
